FILE: rtl/core/grc_pkg.sv
// Shared types, constants and the beam direction table for the grid lidar ray caster.
// Depends on nothing; grid_lidar_ray_caster and grc_rotate in rtl/core import it.
package grc_pkg;

	localparam int BEAM_COUNT    = 61;
	localparam int BEAM_SPAN_DEG = 180;

	// Accumulator holds pose*2^28 + g*d, with g up to about 2^30 and d up to 1023.
	localparam int ACC_W  = 44;
	localparam int GDIR_W = 34;
	localparam int FRAC_W = 28;

	localparam int DEG90_Q16      = 5898240;
	localparam int DEG180_Q16     = 11796480;
	localparam int CORDIC_GAIN_Q14 = 9949;

	localparam int ATAN_Q16 [16] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	// Configuration register indexes.
	localparam logic [1:0] REG_FREE_THR  = 2'd0;
	localparam logic [1:0] REG_MAX_RANGE = 2'd1;
	localparam logic [1:0] REG_MAP_W     = 2'd2;
	localparam logic [1:0] REG_MAP_H     = 2'd3;

	// Request kinds.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_SCAN  = 1'b1;

	typedef struct packed {
		logic signed [15:0] c;
		logic signed [15:0] s;
	} dir_t;

	typedef dir_t [63:0] dir_tab_t;

	typedef struct packed {
		logic       inb;
		logic [8:0] coord;
	} coord_t;

	// CORDIC evaluation of one beam's unit direction, elaboration time only.
	function automatic dir_t beam_dir(input int j);
		longint a;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		bit     neg;
		dir_t   r;
		a   = (longint'(BEAM_SPAN_DEG) * longint'(j - BEAM_COUNT / 2) * 65536) / BEAM_COUNT;
		neg = 1'b0;
		if (a > DEG90_Q16) begin
			a   = a - DEG180_Q16;
			neg = 1'b1;
		end else if (a < -DEG90_Q16) begin
			a   = a + DEG180_Q16;
			neg = 1'b1;
		end
		x = CORDIC_GAIN_Q14;
		y = 0;
		z = a;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_Q16[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_Q16[i];
			end
		end
		if (neg) begin
			x = -x;
			y = -y;
		end
		r.c = 16'(x);
		r.s = 16'(y);
		return r;
	endfunction

	function automatic dir_tab_t build_dirs();
		dir_tab_t t;
		t = '0;
		for (int j = 0; j < BEAM_COUNT; j++) begin
			t[j] = beam_dir(j);
		end
		return t;
	endfunction

	// Truncate a Q28 position toward zero and test it against [0, lim).
	function automatic coord_t decode_coord(input logic [ACC_W-1:0] acc, input logic [8:0] lim);
		coord_t r;
		logic [ACC_W-FRAC_W-1:0] hi;
		hi = acc[ACC_W-1:FRAC_W];
		r.coord = 9'd0;
		r.inb   = 1'b0;
		if (!acc[ACC_W-1]) begin
			r.inb   = (hi < (ACC_W-FRAC_W)'(lim));
			r.coord = hi[8:0];
		end else begin
			// small negative value truncates to column zero
			r.inb = (&hi) && (acc[FRAC_W-1:0] != '0) && (lim != 9'd0);
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/grid_lidar_ray_caster.sv
// Grid lidar ray caster: map cell writes and simulated range scans over a stored grid.
// A write beat is written to the map as it is taken. A scan runs BEAM_COUNT beams in turn,
// each with a heading rotation on the shared multiplier, one map probe per cycle
// through the single memory port, a pipeline drain and one result beat.
// Throughput: one item at a time; the next item is taken once the scan's last beam is queued.
// Reset clears control state and registers to 128/500/256/256; the map is undefined until written.
module grid_lidar_ray_caster #(
	parameter int MAP_SIDE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [15:0] cell_index,
	input  logic [7:0]  cell_value,
	input  logic [7:0]  pose_x,
	input  logic [7:0]  pose_y,
	input  logic signed [15:0] heading_cos,
	input  logic signed [15:0] heading_sin,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  beam_number,
	output logic [9:0]  hit_range,
	output logic        last_beam,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import grc_pkg::*;

	localparam int AW    = $clog2(MAP_SIDE * MAP_SIDE);
	localparam int CELLS = MAP_SIDE * MAP_SIDE;
	localparam logic [8:0] SIDE9 = 9'(MAP_SIDE);
	localparam dir_tab_t DIRS = build_dirs();
	localparam logic [5:0] LAST_BEAM = 6'(BEAM_COUNT - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIR   = 4'b0010,
		ST_MARCH = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0] free_thr_q;
	logic [9:0] max_range_q;
	logic [8:0] map_w_q;
	logic [8:0] map_h_q;
	logic [8:0] w_eff;
	logic [8:0] h_eff;

	// scan context
	logic [7:0]         pose_x_q;
	logic [7:0]         pose_y_q;
	logic signed [15:0] hc_q;
	logic signed [15:0] hs_q;
	logic [5:0]         beam_q;
	logic               rot_start_q;
	logic               rot_done;
	logic signed [GDIR_W-1:0] gc;
	logic signed [GDIR_W-1:0] gs;

	// march state
	logic [ACC_W-1:0] acc_x_q;
	logic [ACC_W-1:0] acc_y_q;
	logic [9:0]       dist_q;
	logic [9:0]       res_q;
	logic             s1_v_q;
	logic             inb_s1;
	logic [9:0]       dist_s1;

	// output register
	logic       out_valid_q;
	logic [5:0] beam_out_q;
	logic [9:0] range_out_q;
	logic       last_out_q;

	// memory port
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_rdata;
	logic [17:0]   probe_addr;
	coord_t        cx;
	coord_t        cy;
	logic          probe_inb;
	logic          issue;
	logic          hit;
	logic          in_fire;
	logic          emit_load;

	assign w_eff = (map_w_q > SIDE9) ? SIDE9 : map_w_q;
	assign h_eff = (map_h_q > SIDE9) ? SIDE9 : map_h_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// Config writes must arrive only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_thr_q  <= 8'd128;
			max_range_q <= 10'd500;
			map_w_q     <= 9'd256;
			map_h_q     <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FREE_THR:  free_thr_q  <= cfg_data[7:0];
				REG_MAX_RANGE: max_range_q <= cfg_data;
				REG_MAP_W:     map_w_q     <= cfg_data[8:0];
				default:       map_h_q     <= cfg_data[8:0];
			endcase
		end
	end

	// Probe address for the current distance; out-of-bounds probes read nothing useful.
	assign cx         = decode_coord(acc_x_q, w_eff);
	assign cy         = decode_coord(acc_y_q, h_eff);
	assign probe_inb  = cx.inb && cy.inb;
	assign probe_addr = ({9'd0, cy.coord} * {9'd0, w_eff}) + {9'd0, cx.coord};

	assign issue = (state_q == ST_MARCH) && (dist_q < max_range_q);
	assign hit   = s1_v_q && inb_s1 && (mem_rdata < free_thr_q);

	// A write beat with an index past the map is dropped.
	assign mem_we   = in_fire && (req_type == REQ_WRITE) && ({1'b0, cell_index} < 17'(CELLS));
	assign mem_addr = (state_q == ST_IDLE) ? cell_index[AW-1:0] : probe_addr[AW-1:0];

	grc_map_mem #(
		.AW(AW)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (cell_value),
		.rdata (mem_rdata)
	);

	grc_rotate u_rot (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rot_start_q),
		.dir    (DIRS[beam_q]),
		.hc     (hc_q),
		.hs     (hs_q),
		.done   (rot_done),
		.gc     (gc),
		.gs     (gs)
	);

	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// Beam sequencer: rotate, march, queue one result, advance to the next beam.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rot_start_q <= 1'b0;
			s1_v_q      <= 1'b0;
			beam_q      <= 6'd0;
		end else begin
			rot_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (req_type == REQ_SCAN)) begin
						beam_q      <= 6'd0;
						rot_start_q <= 1'b1;
						state_q     <= ST_DIR;
					end
				end
				ST_DIR: begin
					s1_v_q <= 1'b0;
					if (rot_done) begin
						state_q <= ST_MARCH;
					end
				end
				ST_MARCH: begin
					// A hit stops the beam; drop the probe issued behind it.
					if (hit) begin
						s1_v_q  <= 1'b0;
						state_q <= ST_EMIT;
					end else if (issue) begin
						s1_v_q <= 1'b1;
					end else if (!s1_v_q) begin
						state_q <= ST_EMIT;
					end else begin
						s1_v_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						if (beam_q == LAST_BEAM) begin
							state_q <= ST_IDLE;
						end else begin
							beam_q      <= beam_q + 6'd1;
							rot_start_q <= 1'b1;
							state_q     <= ST_DIR;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: scan context, accumulators, probe stage.
	always_ff @(posedge clk) begin
		if (in_fire && (req_type == REQ_SCAN)) begin
			pose_x_q <= pose_x;
			pose_y_q <= pose_y;
			hc_q     <= heading_cos;
			hs_q     <= heading_sin;
		end
		if ((state_q == ST_DIR) && rot_done) begin
			// first probe sits at distance one
			acc_x_q <= {{(ACC_W-FRAC_W-8){1'b0}}, pose_x_q, {FRAC_W{1'b0}}}
			           + {{(ACC_W-GDIR_W){gc[GDIR_W-1]}}, gc};
			acc_y_q <= {{(ACC_W-FRAC_W-8){1'b0}}, pose_y_q, {FRAC_W{1'b0}}}
			           + {{(ACC_W-GDIR_W){gs[GDIR_W-1]}}, gs};
			dist_q  <= 10'd1;
		end else if (issue && !hit) begin
			acc_x_q <= acc_x_q + {{(ACC_W-GDIR_W){gc[GDIR_W-1]}}, gc};
			acc_y_q <= acc_y_q + {{(ACC_W-GDIR_W){gs[GDIR_W-1]}}, gs};
			dist_q  <= dist_q + 10'd1;
		end
		if (issue) begin
			inb_s1  <= probe_inb;
			dist_s1 <= dist_q;
		end
		if (state_q == ST_MARCH) begin
			if (hit) begin
				res_q <= dist_s1;
			end else if (!issue && !s1_v_q) begin
				res_q <= dist_q;
			end
		end
	end

	// Output register parts the result beat from the march.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			beam_out_q  <= beam_q;
			range_out_q <= res_q;
			last_out_q  <= (beam_q == LAST_BEAM);
		end
	end

	assign out_valid   = out_valid_q;
	assign beam_number = beam_out_q;
	assign hit_range   = range_out_q;
	assign last_beam   = last_out_q;

	a_probe_stage_in_march: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q |-> (state_q == ST_MARCH))
		else $error("probe stage valid outside march");

	a_range_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit_range != 10'd0))
		else $error("zero range reported");

	a_last_beam_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_beam) |-> (beam_number == LAST_BEAM))
		else $error("last beam flag on wrong beam");

endmodule

FILE: rtl/core/grc_map_mem.sv
// Single-port synchronous map memory with a registered read.
// Depends on nothing outside this file.
module grc_map_mem #(
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/core/grc_rotate.sv
// Rotates a beam direction by the heading with one shared multiplier over four steps.
// Depends on grc_pkg.
module grc_rotate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  grc_pkg::dir_t                     dir,
	input  logic signed [15:0]                hc,
	input  logic signed [15:0]                hs,
	output logic                              done,
	output logic signed [grc_pkg::GDIR_W-1:0] gc,
	output logic signed [grc_pkg::GDIR_W-1:0] gs
);
	import grc_pkg::*;

	logic [2:0]         step_q;
	logic               busy_q;
	logic               done_q;
	logic [1:0]         psel_q;
	logic signed [31:0] prod_q;
	logic signed [15:0] op_a;
	logic signed [15:0] op_b;
	logic signed [GDIR_W-1:0] gc_q;
	logic signed [GDIR_W-1:0] gs_q;
	logic signed [GDIR_W-1:0] prod_ext;

	// gc = c*hc - s*hs, gs = s*hc + c*hs
	always_comb begin
		unique case (step_q[1:0])
			2'd0: begin op_a = dir.c; op_b = hc; end
			2'd1: begin op_a = dir.s; op_b = hs; end
			2'd2: begin op_a = dir.s; op_b = hc; end
			default: begin op_a = dir.c; op_b = hs; end
		endcase
	end

	assign prod_ext = GDIR_W'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			done_q <= busy_q && (step_q == 3'd4);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			gc_q <= '0;
			gs_q <= '0;
		end else if (busy_q) begin
			if (step_q != 3'd4) begin
				prod_q <= op_a * op_b;
				psel_q <= step_q[1:0];
			end
			if (step_q != 3'd0) begin
				unique case (psel_q)
					2'd0: gc_q <= gc_q + prod_ext;
					2'd1: gc_q <= gc_q - prod_ext;
					default: gs_q <= gs_q + prod_ext;
				endcase
			end
		end
	end

	assign done = done_q;
	assign gc   = gc_q;
	assign gs   = gs_q;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for grid_lidar_ray_caster: map writes, scans and register settings.
// Depends on grc_pkg.sv, grid_lidar_ray_caster.sv, grc_map_mem.sv and grc_rotate.sv in rtl/core.
// Expected beam ranges come from a behavioral ray marcher here or a scan row's known range.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import grc_pkg::*;

	localparam int NBEAMS    = 61;
	localparam int FILL_SIZE = 32;      // cells written up front; random settings keep maps inside this
	localparam int CYC_LIMIT = 25000000;

	typedef struct {
		logic [5:0] beam;
		logic [9:0] range;
		logic       last;
	} beam_res_t;

	typedef enum {ROW_CFG, ROW_WRITE, ROW_SCAN} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [1:0]         reg_idx;
		logic [9:0]         reg_val;
		logic [15:0]        idx;
		logic [7:0]         val;
		logic [7:0]         px;
		logic [7:0]         py;
		logic signed [15:0] hc;
		logic signed [15:0] hs;
		int                 known_range;    // -1: ask the predictor
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = REQ_WRITE;
	logic [15:0] cell_index = '0;
	logic [7:0] cell_value = '0;
	logic [7:0] pose_x = '0;
	logic [7:0] pose_y = '0;
	logic signed [15:0] heading_cos = '0;
	logic signed [15:0] heading_sin = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] beam_number;
	logic [9:0] hit_range;
	logic last_beam;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;

	// Shadow of the block's map and registers, updated as beats are taken and registers written.
	logic [7:0] map_shadow [0:65535];
	logic [7:0] thr_q;
	logic [9:0] range_q;
	logic [8:0] width_q;
	logic [8:0] height_q;
	longint beam_c [NBEAMS];
	longint beam_s [NBEAMS];

	beam_res_t range_fifo[$];
	stim_row_t dir_rows[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cnt = 0;
	int err_cnt = 0;
	int cycles = 0;
	int n_scans = 0;
	int n_writes = 0;
	int n_beams = 0;

	grid_lidar_ray_caster u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .cell_index(cell_index), .cell_value(cell_value),
		.pose_x(pose_x), .pose_y(pose_y),
		.heading_cos(heading_cos), .heading_sin(heading_sin),
		.out_valid(out_valid), .out_ready(out_ready),
		.beam_number(beam_number), .hit_range(hit_range), .last_beam(last_beam),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles, %0d beams still expected", cycles,
				range_fifo.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	// Unit beam directions (Q14) by CORDIC, folded into +-90 degrees and negated back.
	task automatic build_beam_dirs();
		longint a, x, y, z, dx, dy;
		bit flip;
		int atan_q16 [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
		for (int j = 0; j < NBEAMS; j++) begin
			a = (longint'(180) * longint'(j - NBEAMS / 2) * 65536) / NBEAMS;
			flip = 1'b0;
			if (a > 64'sd5898240) begin
				a -= 11796480;
				flip = 1'b1;
			end else if (a < -64'sd5898240) begin
				a += 11796480;
				flip = 1'b1;
			end
			x = 9949;
			y = 0;
			z = a;
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= atan_q16[i];
				end else begin
					x += dx;
					y -= dy;
					z += atan_q16[i];
				end
			end
			beam_c[j] = flip ? -x : x;
			beam_s[j] = flip ? -y : y;
		end
	endtask

	function automatic longint q28_trunc(input longint v);
		return (v >= 0) ? (v >>> 28) : -((-v) >>> 28);
	endfunction

	task automatic expect_beat(input beam_res_t r);
		range_fifo = {range_fifo, r};
	endtask

	// March every beam from the pose and queue the first-obstacle range, or the range limit, per beam.
	task automatic predict_scan(input logic [7:0] px, input logic [7:0] py,
			input logic signed [15:0] hc, input logic signed [15:0] hs);
		longint w, h, gc, gs, x, y;
		int d;
		beam_res_t r;
		w = (width_q > 256) ? 256 : width_q;
		h = (height_q > 256) ? 256 : height_q;
		for (int j = 0; j < NBEAMS; j++) begin
			gc = beam_c[j] * longint'(hc) - beam_s[j] * longint'(hs);
			gs = beam_s[j] * longint'(hc) + beam_c[j] * longint'(hs);
			for (d = 1; d < range_q; d++) begin
				x = q28_trunc(gc * d + (longint'(px) <<< 28));
				y = q28_trunc(gs * d + (longint'(py) <<< 28));
				if (x >= 0 && y >= 0 && x < w && y < h && map_shadow[x + y * w] < thr_q)
					break;
			end
			r.beam = 6'(j);
			r.range = 10'(d);
			r.last = (j == NBEAMS - 1);
			expect_beat(r);
		end
	endtask

	task automatic push_known(input int rng);
		beam_res_t r;
		for (int j = 0; j < NBEAMS; j++) begin
			r.beam = 6'(j);
			r.range = 10'(rng);
			r.last = (j == NBEAMS - 1);
			expect_beat(r);
		end
	endtask

	// Offer one beat, hold it until taken, then update the shadow and expectations.
	task automatic send_item(input logic req, input logic [15:0] idx, input logic [7:0] val,
			input logic [7:0] px, input logic [7:0] py,
			input logic signed [15:0] hc, input logic signed [15:0] hs,
			input int known_range);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		cell_index <= idx;
		cell_value <= val;
		pose_x <= px;
		pose_y <= py;
		heading_cos <= hc;
		heading_sin <= hs;
		do @(posedge clk); while (!in_ready);
		if (req == REQ_WRITE) begin
			map_shadow[idx] = val;
			n_writes++;
		end else begin
			n_scans++;
			if (known_range >= 0)
				push_known(known_range);
			else
				predict_scan(px, py, hc, hs);
		end
	endtask

	// Drop valid, drain all beams, then let the write pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (range_fifo.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] ridx, input logic [9:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ridx;
		cfg_data <= val;
		case (ridx)
			REG_FREE_THR:  thr_q = val[7:0];
			REG_MAX_RANGE: range_q = val;
			REG_MAP_W:     width_q = val[8:0];
			REG_MAP_H:     height_q = val[8:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic stim_row_t cfg_row(input logic [1:0] r, input logic [9:0] v);
		stim_row_t s;
		s = '{kind: ROW_CFG, reg_idx: r, reg_val: v, known_range: -1, default: '0};
		return s;
	endfunction

	function automatic stim_row_t wr_row(input logic [15:0] i, input logic [7:0] v);
		stim_row_t s;
		s = '{kind: ROW_WRITE, idx: i, val: v, known_range: -1, default: '0};
		return s;
	endfunction

	function automatic stim_row_t scan_row(input logic [7:0] px, input logic [7:0] py,
			input logic signed [15:0] hc, input logic signed [15:0] hs, input int k);
		stim_row_t s;
		s = '{kind: ROW_SCAN, px: px, py: py, hc: hc, hs: hs, known_range: k, default: '0};
		return s;
	endfunction

	task automatic add_row(input stim_row_t s);
		dir_rows = {dir_rows, s};
	endtask

	// Receiver: random stalls, or a long hold-off while hold_cnt runs down.
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each taken result beat with the oldest expectation.
	always @(posedge clk) begin
		beam_res_t e;
		if (arst_n && out_valid && out_ready) begin
			n_beams++;
			if (range_fifo.size() == 0) begin
				report($sformatf("unexpected beam %0d range %0d", beam_number, hit_range));
			end else begin
				e = range_fifo.pop_front();
				if (beam_number !== e.beam)
					report($sformatf("beam_number %0d, want %0d", beam_number, e.beam));
				if (hit_range !== e.range)
					report($sformatf("beam %0d hit_range %0d, want %0d", e.beam,
						hit_range, e.range));
				if (last_beam !== e.last)
					report($sformatf("beam %0d last_beam %0b, want %0b", e.beam,
						last_beam, e.last));
			end
		end
	end

	// Random heading: mostly a unit vector, sometimes any 16-bit pair.
	task automatic pick_heading(output logic signed [15:0] hc, output logic signed [15:0] hs);
		real ang;
		if ($urandom_range(9) == 0) begin
			hc = 16'($urandom);
			hs = 16'($urandom);
		end else begin
			ang = $urandom_range(35999) * 3.14159265358979 / 18000.0;
			hc = 16'($rtoi(16384.0 * $cos(ang)));
			hs = 16'($rtoi(16384.0 * $sin(ang)));
		end
	endtask

	// Random setting whose in-use map stays inside the pre-filled cells.
	task automatic random_config();
		int w, h, wc, hmax, sel;
		sel = $urandom_range(19);
		if (sel == 0)
			w = 0;
		else if (sel == 1)
			w = $urandom_range(257, 511);
		else
			w = $urandom_range(1, 40);
		wc = (w > 256) ? 256 : w;
		hmax = (wc == 0) ? 511 : FILL_SIZE / wc;
		if (hmax > 511)
			hmax = 511;
		h = (hmax == 0) ? 0 : $urandom_range(1, hmax);
		cfg_write(REG_MAP_W, 10'(w));
		cfg_write(REG_MAP_H, 10'(h));
		cfg_write(REG_FREE_THR, 10'($urandom_range(255)));
		if ($urandom_range(7) == 0)
			cfg_write(REG_MAX_RANGE, 10'($urandom_range(1, 1023)));
		else
			cfg_write(REG_MAX_RANGE, 10'($urandom_range(1, 48)));
	endtask

	initial begin
		logic signed [15:0] hc, hs;
		int wc, hc_lim;
		stim_row_t row;
		build_beam_dirs();
		thr_q = 8'd128;
		range_q = 10'd500;
		width_q = 9'd256;
		height_q = 9'd256;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every cell any scan below may probe.
		for (int i = 0; i < FILL_SIZE; i++)
			send_item(REQ_WRITE, 16'(i), 8'($urandom), 8'd0, 8'd0, 16'sd0, 16'sd0, -1);
		wait_idle();

		// Directed rows: range limit and zero-width corners, headings on an 8x4 map, then oversized maps.
		add_row(cfg_row(REG_MAX_RANGE, 10'd1));
		add_row(scan_row(8'd0, 8'd0, 16'sd16384, 16'sd0, 1));
		add_row(cfg_row(REG_MAX_RANGE, 10'd0));
		add_row(scan_row(8'd255, 8'd255, -16'sd16384, 16'sd0, 1));
		add_row(cfg_row(REG_MAP_W, 10'd0));
		add_row(cfg_row(REG_MAX_RANGE, 10'd1023));
		add_row(scan_row(8'd255, 8'd255, 16'sd0, -16'sd16384, 1023));
		add_row(cfg_row(REG_MAP_W, 10'd8));
		add_row(cfg_row(REG_MAP_H, 10'd4));
		add_row(cfg_row(REG_MAX_RANGE, 10'd40));
		add_row(cfg_row(REG_FREE_THR, 10'd0));
		add_row(scan_row(8'd4, 8'd2, 16'sd16384, 16'sd0, 40));
		add_row(cfg_row(REG_FREE_THR, 10'd255));
		add_row(wr_row(16'd0, 8'd255));
		add_row(wr_row(16'hFFFF, 8'd0));
		add_row(scan_row(8'd0, 8'd0, 16'sd16384, 16'sd0, -1));
		add_row(cfg_row(REG_FREE_THR, 10'd128));
		add_row(scan_row(8'd3, 8'd1, 16'sd0, 16'sd16384, -1));
		add_row(scan_row(8'd7, 8'd0, -16'sd16384, 16'sd0, -1));
		add_row(scan_row(8'd5, 8'd3, 16'sd0, -16'sd16384, -1));
		add_row(scan_row(8'd4, 8'd2, 16'sh7FFF, -16'sh8000, -1));
		// Short range keeps the oversized single-row and two-column maps and the single-column map near the pose.
		add_row(cfg_row(REG_MAX_RANGE, 10'd8));
		add_row(cfg_row(REG_MAP_W, 10'd511));
		add_row(cfg_row(REG_MAP_H, 10'd1));
		add_row(scan_row(8'd16, 8'd0, 16'sd11585, 16'sd11585, -1));
		add_row(cfg_row(REG_MAP_W, 10'd2));
		add_row(cfg_row(REG_MAP_H, 10'd511));
		add_row(scan_row(8'd1, 8'd8, 16'sd0, 16'sd16384, -1));
		add_row(cfg_row(REG_MAP_W, 10'd1));
		add_row(cfg_row(REG_MAP_H, 10'd256));
		add_row(scan_row(8'd0, 8'd16, -16'sd11585, 16'sd11585, -1));
		add_row(scan_row(8'd0, 8'd0, 16'sd0, 16'sd0, -1));

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			case (row.kind)
				ROW_CFG: begin
					wait_idle();
					cfg_write(row.reg_idx, row.reg_val);
				end
				ROW_WRITE: send_item(REQ_WRITE, row.idx, row.val, 8'd0, 8'd0, 16'sd0,
					16'sd0, -1);
				ROW_SCAN: send_item(REQ_SCAN, 16'd0, 8'd0, row.px, row.py, row.hc, row.hs,
					row.known_range);
			endcase
		end
		wait_idle();

		// Random phases, one per idling mix, with a fresh setting each.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				3: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			random_config();
			if (ph == 0) begin
				// Hold the receiver off so the result path backs up into the input.
				@(negedge clk);
				hold_cnt = 3000;
				@(posedge clk);
			end
			wc = (width_q > 256) ? 256 : width_q;
			hc_lim = (height_q > 256) ? 256 : height_q;
			for (int k = 0; k < 15; k++) begin
				if ($urandom_range(9) < 3) begin
					if ($urandom_range(9) == 0)
						send_item(REQ_WRITE, 16'($urandom_range(FILL_SIZE, 65535)),
							8'($urandom), 8'd0, 8'd0, 16'sd0, 16'sd0, -1);
					else
						send_item(REQ_WRITE, 16'($urandom_range(FILL_SIZE - 1)),
							8'($urandom), 8'd0, 8'd0, 16'sd0, 16'sd0, -1);
				end else begin
					pick_heading(hc, hs);
					if ($urandom_range(4) == 0 || wc == 0 || hc_lim == 0)
						send_item(REQ_SCAN, 16'($urandom), 8'($urandom), 8'($urandom),
							8'($urandom), hc, hs, -1);
					else
						send_item(REQ_SCAN, 16'($urandom), 8'($urandom),
							8'($urandom_range(wc - 1)), 8'($urandom_range(hc_lim - 1)),
							hc, hs, -1);
				end
			end
			wait_idle();
		end

		repeat (100) @(posedge clk);
		$display("covered %0d map writes and %0d scans, %0d beams compared", n_writes,
			n_scans, n_beams);
		$display("settings: zero, single-row/column, oversized and 8x4 maps; ranges 0..1023");
		if (err_cnt == 0 && range_fifo.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d beams never seen", err_cnt, range_fifo.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
